### rtl/core/chd_pkg.sv
// Package for the chunked body decoder: widths, phase and result codes,
// and the byte classification functions. No dependencies.

package chd_pkg;

   localparam int COUNT_WIDTH = 32;
   localparam int DIGIT_WIDTH = 4;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [1:0] TRAILER_LEN = 2'd2;
   localparam logic [3:0] DIGIT_COUNT_MAX = 4'd15;

   typedef enum logic [2:0] {
      PH_BLANKS  = 3'd0,
      PH_DIGITS  = 3'd1,
      PH_REST    = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_TRAILER = 3'd4,
      PH_DONE    = 3'd5,
      PH_ERROR   = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_END   = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef struct packed {
      logic [1:0] result_kind;
      logic [7:0] payload_byte;
   } result_type;

   function automatic logic is_hex(input logic [7:0] b);
      return (b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
   endfunction

   function automatic logic [DIGIT_WIDTH-1:0] hex_value(input logic [7:0] b);
      logic [7:0] v;
      v = 8'h00;
      if (b inside {[8'h30:8'h39]}) begin
         v = b - 8'h30;
      end else if (b inside {[8'h41:8'h46]}) begin
         v = b - 8'h37;
      end else if (b inside {[8'h61:8'h66]}) begin
         v = b - 8'h57;
      end
      return v[DIGIT_WIDTH-1:0];
   endfunction

   // Space, tab, LF, VT, FF and CR.
   function automatic logic is_blank(input logic [7:0] b);
      return (b == 8'h20) || (b inside {[8'h09:8'h0D]});
   endfunction

endpackage

### rtl/core/chd_if.sv
// Stream interfaces for the chunked body decoder: the body byte channel
// and the result channel. No dependencies.

interface chd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] body_byte;

   modport source (output valid, output body_byte, input ready);
   modport sink (input valid, input body_byte, output ready);
endinterface

interface chd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] result_kind;
   logic [7:0] payload_byte;

   modport source (output valid, output result_kind, output payload_byte, input ready);
   modport sink (input valid, input result_kind, input payload_byte, output ready);
endinterface

### rtl/core/chd_decoder.sv
// Input register and chunk parser state for the chunked body decoder.
// Depends on chd_pkg.

module chd_decoder
   import chd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_byte,
   input  logic       out_space,
   output logic       out_push,
   output result_type out_result
);

   logic                   byte_valid_ff, byte_valid_in;
   logic [7:0]             byte_ff;
   phase_type              phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] remain_ff, remain_in;
   logic                   cr_seen_ff, cr_seen_in;
   logic [3:0]             digits_ff, digits_in;
   logic [1:0]             trailer_ff, trailer_in;
   logic                   advance;

   assign advance       = byte_valid_ff && out_space;
   assign in_ready      = !byte_valid_ff || advance;
   assign byte_valid_in = (in_valid && in_ready) || (byte_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         byte_ff <= in_byte;
      end
      if (reset) begin
         byte_valid_ff <= 1'b0;
         phase_ff      <= PH_BLANKS;
         remain_ff     <= '0;
         cr_seen_ff    <= 1'b0;
         digits_ff     <= '0;
         trailer_ff    <= '0;
      end else begin
         byte_valid_ff <= byte_valid_in;
         if (advance) begin
            phase_ff   <= phase_in;
            remain_ff  <= remain_in;
            cr_seen_ff <= cr_seen_in;
            digits_ff  <= digits_in;
            trailer_ff <= trailer_in;
         end
      end
   end

   always_comb begin
      logic [COUNT_WIDTH-1:0] dec;
      logic [1:0]             tdec;
      logic                   hex;
      phase_type              ph;
      dec        = remain_ff - 1'b1;
      tdec       = trailer_ff - 1'b1;
      hex        = is_hex(byte_ff);
      ph         = phase_ff;
      phase_in   = phase_ff;
      remain_in  = remain_ff;
      cr_seen_in = cr_seen_ff;
      digits_in  = digits_ff;
      trailer_in = trailer_ff;
      out_push   = 1'b0;
      out_result = '{result_kind: KIND_DATA, payload_byte: 8'h00};

      case (phase_ff)
         PH_PAYLOAD: begin
            remain_in = dec;
            if (dec == '0) begin
               phase_in   = PH_TRAILER;
               trailer_in = TRAILER_LEN;
            end
            out_push   = 1'b1;
            out_result = '{result_kind: KIND_DATA, payload_byte: byte_ff};
         end
         PH_TRAILER: begin
            trailer_in = tdec;
            if (tdec == '0) begin
               phase_in   = PH_BLANKS;
               remain_in  = '0;
               cr_seen_in = 1'b0;
               digits_in  = '0;
            end
         end
         PH_BLANKS, PH_DIGITS, PH_REST: begin
            if (byte_ff == CHAR_LF && cr_seen_ff) begin
               // A CR LF pair closes the size line.
               cr_seen_in = 1'b0;
               if (digits_ff == '0) begin
                  phase_in   = PH_ERROR;
                  out_push   = 1'b1;
                  out_result = '{result_kind: KIND_ERROR, payload_byte: 8'h00};
               end else if (remain_ff == '0) begin
                  phase_in   = PH_DONE;
                  out_push   = 1'b1;
                  out_result = '{result_kind: KIND_END, payload_byte: 8'h00};
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end else begin
               cr_seen_in = (byte_ff == CHAR_CR);
               if (ph == PH_BLANKS) begin
                  if (hex) begin
                     ph = PH_DIGITS;
                  end else if (!is_blank(byte_ff)) begin
                     ph = PH_REST;
                  end
               end else if (ph == PH_DIGITS && !hex) begin
                  ph = PH_REST;
               end
               phase_in = ph;
               if (ph == PH_DIGITS && hex) begin
                  // The top digit must be clear before another digit shifts in.
                  if (remain_ff[COUNT_WIDTH-1 -: DIGIT_WIDTH] != '0) begin
                     phase_in   = PH_ERROR;
                     cr_seen_in = 1'b0;
                     out_push   = 1'b1;
                     out_result = '{result_kind: KIND_ERROR, payload_byte: 8'h00};
                  end else begin
                     remain_in = {remain_ff[COUNT_WIDTH-DIGIT_WIDTH-1:0], hex_value(byte_ff)};
                     if (digits_ff != DIGIT_COUNT_MAX) begin
                        digits_in = digits_ff + 1'b1;
                     end
                  end
               end
            end
         end
         default: begin
         end
      endcase

      if (!advance) begin
         out_push = 1'b0;
      end
   end

endmodule

### rtl/core/chd_out_queue.sv
// Two-entry result queue that decouples the parser from the result channel.
// Depends on chd_pkg.

module chd_out_queue
   import chd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_result,
   output logic       space,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_result
);

   result_type entry_ff [2];
   logic       rd_ptr_ff, rd_ptr_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign space      = (count_ff != 2'd2);
   assign out_valid  = (count_ff != 2'd0);
   assign out_result = entry_ff[rd_ptr_ff];
   assign pop        = out_valid && out_ready;

   always_comb begin
      rd_ptr_in = rd_ptr_ff ^ pop;
      wr_ptr_in = wr_ptr_ff ^ push;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_result;
      end
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/core/http_chunked_body_decoder.sv
// Top level of the HTTP/1.1 chunked body decoder.
// Depends on chd_pkg, chd_if, chd_decoder and chd_out_queue.
//
//   channel  direction  payload                              transfer
//   req_     in         body_byte[7:0]                       valid && ready
//   rsp_     out        result_kind[1:0], payload_byte[7:0]  valid && ready
//
// One byte is taken per cycle while the result channel keeps up; a result
// leaves through the input register, then the result queue.
// The parser can take a new byte as it finishes the last, so the sustained
// rate is one byte per cycle while the result channel keeps up.
// The two-entry result queue absorbs a stall; req_chan.ready drops only when
// the queue is full and the input register still holds a byte.
// Reset is synchronous and returns the parser to the start of a size line.

module http_chunked_body_decoder
   import chd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   chd_req_if.sink req_chan,
   chd_rsp_if.source rsp_chan
);

   logic       queue_space;
   logic       result_push;
   result_type result_new;
   result_type result_head;

   chd_decoder u_decoder (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .in_ready   (req_chan.ready),
      .in_byte    (req_chan.body_byte),
      .out_space  (queue_space),
      .out_push   (result_push),
      .out_result (result_new)
   );

   chd_out_queue u_out_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (result_push),
      .push_result (result_new),
      .space       (queue_space),
      .out_valid   (rsp_chan.valid),
      .out_ready   (rsp_chan.ready),
      .out_result  (result_head)
   );

   assign rsp_chan.result_kind  = result_head.result_kind;
   assign rsp_chan.payload_byte = result_head.payload_byte;

endmodule
